FILE: hdl/char_lcd_nibble_write_sequencer_top_macros.svh
// Assertion macros shared by the checker.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_TOP_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LCDWS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define LCDWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/lcdws_pkg.sv
`timescale 1ns / 1ps

package lcdws_pkg;

	localparam int WAIT_W = 20;

	// command codes
	localparam logic [2:0] MODE_INSTR = 3'd0;
	localparam logic [2:0] MODE_DATA  = 3'd1;
	localparam logic [2:0] MODE_INIT  = 3'd2;
	localparam logic [2:0] MODE_GOTO  = 3'd3;
	localparam logic [2:0] MODE_CHAR  = 3'd4;

	// config register indexes
	localparam logic [2:0] REG_POWERUP = 3'd0;
	localparam logic [2:0] REG_WAKE    = 3'd1;
	localparam logic [2:0] REG_MODE    = 3'd2;
	localparam logic [2:0] REG_SLOW    = 3'd3;
	localparam logic [2:0] REG_FAST    = 3'd4;

	localparam logic [WAIT_W-1:0] POWERUP_RST = 20'd200000;
	localparam logic [WAIT_W-1:0] WAKE_RST    = 20'd4000;
	localparam logic [WAIT_W-1:0] MODE_RST    = 20'd3000;
	localparam logic [WAIT_W-1:0] SLOW_RST    = 20'd2000;
	localparam logic [WAIT_W-1:0] FAST_RST    = 20'd40;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] byte_value;
		logic       row;
		logic [5:0] column;
		logic [2:0] glyph_slot;
	} cmd_t;

	typedef struct packed {
		logic              strobe_res;
		logic              reg_select;
		logic [3:0]        nibble;
		logic [WAIT_W-1:0] wait_after_us;
		logic              last;
	} evt_t;

	typedef struct packed {
		logic [WAIT_W-1:0] powerup_wait_us;
		logic [WAIT_W-1:0] wake_wait_us;
		logic [WAIT_W-1:0] mode_nibble_wait_us;
		logic [WAIT_W-1:0] slow_cmd_wait_us;
		logic [WAIT_W-1:0] fast_cmd_wait_us;
	} cfg_t;

	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_INIT,
		KIND_CHAR
	} kind_t;

	// classified job handed from front to back
	typedef struct packed {
		kind_t      kind;
		logic       rs;
		logic [7:0] byte_value;
		logic [2:0] glyph_slot;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

FILE: hdl/char_lcd_nibble_write_sequencer_top.sv
`timescale 1ns / 1ps

// Character LCD write sequencer for a 4-bit parallel bus. Each accepted command
// expands into bus events on the out channel: an enable strobe with register
// select and a nibble, or a wait-only event, each with the microseconds to hold
// before the next event and a last flag on the command's final event. Byte
// commands give 2 events, goto 2, init 13, define-char 18; codes 5 to 7 are
// accepted and give nothing. The back end issues one event per clock while
// out_ready does not stall it and the queue holds a job; a short job queue lets
// commands be accepted while the previous ones are still being played out. The
// wait registers are written through cfg_* and should only be changed while no
// command is in flight.
module char_lcd_nibble_write_sequencer_top import lcdws_pkg::*; #(
	parameter int FIFO_DEPTH = 4 // job queue entries, 2 or more
) (
	input  logic              clk,
	input  logic              arst_n,
	// command transfer
	input  logic              in_valid,
	output logic              in_ready,
	input  cmd_t              in_data,
	// bus event transfer
	output logic              out_valid,
	input  logic              out_ready,
	output evt_t              out_data,
	// wait register writes
	input  logic              cfg_wr_en,
	input  logic [2:0]        cfg_index,
	input  logic [WAIT_W-1:0] cfg_data
);

	cfg_t    cfg;
	q_stat_t q_stat;
	job_t    push_job, head_job;
	logic    push, pop;

	lcdws_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// front: classify the command, fold goto into an instruction byte
	lcdws_front u_front (
		.in_valid (in_valid),
		.in_data  (in_data),
		.in_ready (in_ready),
		.q_stat   (q_stat),
		.push     (push),
		.job      (push_job)
	);

	// decouples command intake from event issue
	lcdws_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (push_job),
		.pop    (pop),
		.rd_job (head_job),
		.stat   (q_stat)
	);

	// back: walk the head job one event per cycle into the output register, unless out_ready stalls it
	lcdws_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.job       (head_job),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: hdl/lcdws_cfg.sv
`timescale 1ns / 1ps

module lcdws_cfg import lcdws_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [2:0]        index,
	input  logic [WAIT_W-1:0] data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.powerup_wait_us     <= POWERUP_RST;
			cfg_q.wake_wait_us        <= WAKE_RST;
			cfg_q.mode_nibble_wait_us <= MODE_RST;
			cfg_q.slow_cmd_wait_us    <= SLOW_RST;
			cfg_q.fast_cmd_wait_us    <= FAST_RST;
		end else if (wr_en) begin
			case (index)
				REG_POWERUP: cfg_q.powerup_wait_us     <= data;
				REG_WAKE:    cfg_q.wake_wait_us        <= data;
				REG_MODE:    cfg_q.mode_nibble_wait_us <= data;
				REG_SLOW:    cfg_q.slow_cmd_wait_us    <= data;
				REG_FAST:    cfg_q.fast_cmd_wait_us    <= data;
				default: ; // unmapped index, dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/lcdws_front.sv
`timescale 1ns / 1ps

module lcdws_front import lcdws_pkg::*; (
	input  logic    in_valid,
	input  cmd_t    in_data,
	output logic    in_ready,
	input  q_stat_t q_stat,
	output logic    push,
	output job_t    job
);

	logic known;

	always_comb begin
		job            = '0;
		job.kind       = KIND_BYTE;
		job.byte_value = in_data.byte_value;
		job.glyph_slot = in_data.glyph_slot;
		known          = 1'b1;
		case (in_data.mode)
			MODE_INSTR: job.rs = 1'b0;
			MODE_DATA:  job.rs = 1'b1;
			MODE_INIT:  job.kind = KIND_INIT;
			MODE_GOTO:  job.byte_value = {1'b1, in_data.row, in_data.column};
			MODE_CHAR:  job.kind = KIND_CHAR;
			default:    known = 1'b0; // no events, swallowed
		endcase
	end

	assign in_ready = !q_stat.full;
	assign push     = in_valid && in_ready && known;

endmodule

FILE: hdl/lcdws_fifo.sv
`timescale 1ns / 1ps

module lcdws_fifo import lcdws_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    wr_job,
	input  logic    pop,
	output job_t    rd_job,
	output q_stat_t stat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign stat.full  = (count_q == CNT_FULL);
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_job     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/lcdws_back.sv
`timescale 1ns / 1ps

module lcdws_back import lcdws_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  job_t    job,
	input  q_stat_t q_stat,
	output logic    pop,
	output logic    out_valid,
	input  logic    out_ready,
	output evt_t    out_data
);

	// step positions within a job
	localparam logic [4:0] INIT_MODE_STEP = 5'd4;
	localparam logic [4:0] INIT_BYTE0     = 5'd5;
	localparam logic [4:0] INIT_LAST      = 5'd12;
	localparam logic [4:0] CHAR_DATA0     = 5'd2;
	localparam logic [4:0] CHAR_LAST      = 5'd17;

	localparam logic [3:0] WAKE_NIB = 4'h3;
	localparam logic [3:0] MODE_NIB = 4'h2;

	localparam logic [7:0] INIT_FUNC  = 8'h28;
	localparam logic [7:0] INIT_DISP  = 8'h0F;
	localparam logic [7:0] INIT_ENTRY = 8'h06;
	localparam logic [7:0] INIT_SHIFT = 8'h10;

	logic [4:0] step_q;
	logic       out_valid_q;
	evt_t       out_q;

	logic       advance, fire;
	logic       byte_evt, half, rs;
	logic [7:0] sel_byte;
	logic [4:0] sub;
	evt_t       ev;

	always_comb begin
		ev       = '0;
		byte_evt = 1'b0;
		half     = step_q[0];
		rs       = 1'b0;
		sel_byte = job.byte_value;
		sub      = '0;
		case (job.kind)
			KIND_BYTE: begin
				byte_evt = 1'b1;
				rs       = job.rs;
				ev.last  = step_q[0];
			end
			KIND_INIT: begin
				if (step_q == '0) begin
					ev.wait_after_us = cfg.powerup_wait_us;
				end else if (step_q < INIT_MODE_STEP) begin
					ev.strobe_res    = 1'b1;
					ev.nibble        = WAKE_NIB;
					ev.wait_after_us = cfg.wake_wait_us;
				end else if (step_q == INIT_MODE_STEP) begin
					ev.strobe_res    = 1'b1;
					ev.nibble        = MODE_NIB;
					ev.wait_after_us = cfg.mode_nibble_wait_us;
				end else begin
					byte_evt = 1'b1;
					sub      = step_q - INIT_BYTE0;
					half     = sub[0];
					case (sub[2:1])
						2'd0:    sel_byte = INIT_FUNC;
						2'd1:    sel_byte = INIT_DISP;
						2'd2:    sel_byte = INIT_ENTRY;
						default: sel_byte = INIT_SHIFT;
					endcase
					ev.last = (step_q == INIT_LAST);
				end
			end
			KIND_CHAR: begin
				byte_evt = 1'b1;
				if (step_q < CHAR_DATA0) begin
					// CGRAM address of the slot
					sel_byte = {2'b01, job.glyph_slot, 3'b000};
				end else begin
					sub      = step_q - CHAR_DATA0;
					half     = sub[0];
					rs       = 1'b1;
					sel_byte = sub[1] ? 8'h00 : job.byte_value;
					ev.last  = (step_q == CHAR_LAST);
				end
			end
			default: ;
		endcase
		if (byte_evt) begin
			ev.strobe_res = 1'b1;
			ev.reg_select = rs;
			ev.nibble     = half ? sel_byte[3:0] : sel_byte[7:4];
			if (!half) begin
				ev.wait_after_us = '0;
			end else if (!rs && (sel_byte[1:0] != 2'b00)) begin
				ev.wait_after_us = cfg.slow_cmd_wait_us;
			end else begin
				ev.wait_after_us = cfg.fast_cmd_wait_us;
			end
		end
	end

	assign advance = !out_valid_q || out_ready;
	assign fire    = advance && !q_stat.empty;
	assign pop     = fire && ev.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else if (advance) begin
			out_valid_q <= !q_stat.empty;
			if (fire) begin
				step_q <= ev.last ? '0 : step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= ev;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: hdl/lcdws_checker.sv
`timescale 1ns / 1ps
`include "char_lcd_nibble_write_sequencer_top_macros.svh"

module lcdws_checker import lcdws_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input cmd_t              in_data,
	input logic              out_valid,
	input logic              out_ready,
	input evt_t              out_data
);

	// a command offer holds until taken
	`LCDWS_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && !in_ready,
		in_valid && $stable(in_data), "waiting command changed")

	// a stalled event must hold
	`LCDWS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_data), "stalled event changed")

	// wait-only events drive idle lines and never end a command
	`LCDWS_ASSERT_NOW(a_wait_only, clk, arst_n, out_valid && !out_data.strobe_res,
		out_data.reg_select == 1'b0 && out_data.nibble == 4'h0 && !out_data.last,
		"wait-only event malformed")

	// every command ends on a strobe
	`LCDWS_ASSERT_NOW(a_last_strobe, clk, arst_n, out_valid && out_data.last,
		out_data.strobe_res, "last event is not a strobe")

endmodule

bind char_lcd_nibble_write_sequencer_top lcdws_checker u_lcdws_checker (.*);
